### src/dlr_pkg.sv
// Shared constants, codes and transaction types for the DDA line rasterizer.
// No dependencies; every other source file imports this package.
package dlr_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int COORD_BITS = 32;
   localparam int CNT_W      = 22;
   localparam int DVD_W      = CNT_W + FRAC_BITS;
   localparam int POS_W      = COORD_BITS + FRAC_BITS + 1;
   localparam int STEP_W     = DVD_W + 1;
   localparam int OFS_W      = FRAC_BITS + 2;
   localparam int CRD_W      = COORD_BITS + 2;
   localparam int DIV_CNT_W  = $clog2(DVD_W + 1);

   localparam int LIMIT_ORTHO = 500000;
   localparam int LIMIT_PERSP = 50000;

   localparam logic [15:0] RST_CANVAS_WIDTH  = 16'd1920;
   localparam logic [15:0] RST_CANVAS_HEIGHT = 16'd1080;
   localparam logic [7:0]  RST_THICKNESS     = 8'd1;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_CANVAS_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CANVAS_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORTHO_MODE    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_AA_MODE       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_THICKNESS     = 3'd4;

   // Order of the quotients computed at line setup
   localparam logic [2:0] DIV_X      = 3'd0;
   localparam logic [2:0] DIV_Y      = 3'd1;
   localparam logic [2:0] DIV_DEPTH  = 3'd2;
   localparam logic [2:0] DIV_COLOR0 = 3'd3;
   localparam logic [2:0] DIV_LAST   = 3'd6;

   typedef struct packed {
      logic        func;
      logic [31:0] start_x;
      logic [31:0] start_y;
      logic [31:0] end_x;
      logic [31:0] end_y;
      logic [31:0] start_color;
      logic [31:0] end_color;
      logic [31:0] start_depth;
      logic [31:0] end_depth;
      logic        start_shown;
      logic        end_shown;
   } req_item_type;

   typedef struct packed {
      logic [31:0] pixel_x;
      logic [31:0] pixel_y;
      logic [31:0] pixel_color;
      logic [31:0] pixel_depth;
      logic [7:0]  pixel_thickness;
      logic        blend_pixel;
      logic        line_done;
   } rsp_item_type;

   typedef struct packed {
      logic                  valid;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
   } csr_write_type;

   typedef struct packed {
      logic       capture;
      logic       init;
      logic       div_start;
      logic       div_capture;
      logic [2:0] div_idx;
      logic       step;
      logic       emit_zero;
      logic       emit_first;
      logic       emit_second;
   } dlr_cmd_type;

   typedef struct packed {
      logic drop;
      logic zero_len;
      logic div_done;
      logic out_free;
      logic last_step;
      logic second_needed;
      logic aa;
   } dlr_status_type;

endpackage

### src/dlr_if.sv
// Channel interfaces of the line rasterizer: request, response and CSR write.
// Depends on dlr_pkg for the CSR widths.
interface dlr_req_if;
   logic               valid;
   logic               ready;
   logic               func;
   logic signed [31:0] start_x;
   logic signed [31:0] start_y;
   logic signed [31:0] end_x;
   logic signed [31:0] end_y;
   logic        [31:0] start_color;
   logic        [31:0] end_color;
   logic signed [31:0] start_depth;
   logic signed [31:0] end_depth;
   logic               start_shown;
   logic               end_shown;

   modport source (output valid, func, start_x, start_y, end_x, end_y, start_color,
                   end_color, start_depth, end_depth, start_shown, end_shown,
                   input ready);
   modport sink (input valid, func, start_x, start_y, end_x, end_y, start_color,
                 end_color, start_depth, end_depth, start_shown, end_shown,
                 output ready);
endinterface

interface dlr_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pixel_x;
   logic signed [31:0] pixel_y;
   logic        [31:0] pixel_color;
   logic signed [31:0] pixel_depth;
   logic        [7:0]  pixel_thickness;
   logic               blend_pixel;
   logic               line_done;

   modport source (output valid, pixel_x, pixel_y, pixel_color, pixel_depth,
                   pixel_thickness, blend_pixel, line_done, input ready);
   modport sink (input valid, pixel_x, pixel_y, pixel_color, pixel_depth,
                 pixel_thickness, blend_pixel, line_done, output ready);
endinterface

interface dlr_csr_if import dlr_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### src/dlr_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle, shared by line setup.
// Depends on dlr_pkg for operand widths.
module dlr_divider import dlr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [CNT_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient,
   output logic [CNT_W-1:0] remainder
);

   logic [DVD_W-1:0]     quo_ff, quo_in;
   logic [CNT_W-1:0]     rem_ff, rem_in;
   logic [CNT_W-1:0]     div_ff, div_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W:0]       shifted;
   logic                 ge;

   assign shifted = {rem_ff, quo_ff[DVD_W-1]};
   assign ge      = shifted >= {1'b0, div_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = DIV_CNT_W'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DVD_W-2:0], ge};
         rem_in = ge ? CNT_W'(shifted - {1'b0, div_ff}) : shifted[CNT_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

### src/dlr_datapath.sv
// Datapath: CSRs, line test and setup, DDA accumulators, pixel output register.
// Depends on dlr_pkg and instantiates dlr_divider.
module dlr_datapath import dlr_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  req_item_type   req_item,
   input  csr_write_type  csr_wr,
   input  dlr_cmd_type    cmd,
   output dlr_status_type status,
   output logic           rsp_valid,
   output rsp_item_type   rsp_item,
   input  logic           rsp_ready
);

   localparam logic [FRAC_BITS-1:0] HALF = FRAC_BITS'(1) << (FRAC_BITS - 1);

   // CSRs
   logic [15:0] width_ff, height_ff;
   logic        ortho_ff, aa_ff;
   logic [7:0]  thick_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RST_CANVAS_WIDTH;
         height_ff <= RST_CANVAS_HEIGHT;
         ortho_ff  <= 1'b0;
         aa_ff     <= 1'b0;
         thick_ff  <= RST_THICKNESS;
      end else if (csr_wr.valid) begin
         case (csr_wr.index)
            CSR_CANVAS_WIDTH:  width_ff  <= csr_wr.data;
            CSR_CANVAS_HEIGHT: height_ff <= csr_wr.data;
            CSR_ORTHO_MODE:    ortho_ff  <= csr_wr.data[0];
            CSR_AA_MODE:       aa_ff     <= csr_wr.data[0];
            CSR_THICKNESS:     thick_ff  <= csr_wr.data[7:0];
            default: ;
         endcase
      end
   end

   // Captured load transaction
   logic signed [CRD_W-1:0] sx_ff, sy_ff, ex_ff, ey_ff;
   logic [31:0]             c0_ff, c1_ff, d0_ff, d1_ff;
   logic                    shown_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sx_ff    <= CRD_W'($signed(req_item.start_x[COORD_BITS-1:0]));
         sy_ff    <= CRD_W'($signed(req_item.start_y[COORD_BITS-1:0]));
         ex_ff    <= CRD_W'($signed(req_item.end_x[COORD_BITS-1:0]));
         ey_ff    <= CRD_W'($signed(req_item.end_y[COORD_BITS-1:0]));
         c0_ff    <= req_item.start_color;
         c1_ff    <= req_item.end_color;
         d0_ff    <= req_item.start_depth;
         d1_ff    <= req_item.end_depth;
         shown_ff <= req_item.start_shown & req_item.end_shown;
      end
   end

   // Visibility test and step count
   logic signed [CRD_W-1:0] w_s, h_s, lim_s, nlim_s, wl_s, hl_s;
   logic signed [CRD_W-1:0] dx, dy, adx, ady, t_full;
   logic                    drop;

   always_comb begin
      w_s    = $signed(CRD_W'(width_ff));
      h_s    = $signed(CRD_W'(height_ff));
      lim_s  = ortho_ff ? $signed(CRD_W'(LIMIT_ORTHO)) : $signed(CRD_W'(LIMIT_PERSP));
      nlim_s = -lim_s;
      wl_s   = w_s + lim_s;
      hl_s   = h_s + lim_s;
      drop = (sx_ff > w_s && ex_ff > w_s) || (sx_ff < 0 && ex_ff < 0) ||
             (sy_ff > h_s && ey_ff > h_s) || (sy_ff < 0 && ey_ff < 0) ||
             sx_ff > wl_s || sy_ff > hl_s || sx_ff < nlim_s || sy_ff < nlim_s ||
             ex_ff > wl_s || ey_ff > hl_s || ex_ff < nlim_s || ey_ff < nlim_s ||
             !shown_ff || (c0_ff[7:0] == 8'd0 && c1_ff[7:0] == 8'd0);
      dx     = ex_ff - sx_ff;
      dy     = ey_ff - sy_ff;
      adx    = dx < 0 ? -dx : dx;
      ady    = dy < 0 ? -dy : dy;
      t_full = adx > ady ? adx : ady;
   end

   // Per-line setup registers
   logic [CNT_W-1:0] total_ff, count_ff, adx_ff, ady_ff;
   logic             sgnx_ff, sgny_ff, dsgn_ff;
   logic [32:0]      dmag_ff;
   logic [7:0]       cmag_ff [4];
   logic             csgn_ff [4];
   logic [8:0]       cdif    [4];
   logic [32:0]      ddif;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         cdif[k] = {1'b0, c1_ff[8*k +: 8]} - {1'b0, c0_ff[8*k +: 8]};
      end
      ddif = {d1_ff[31], d1_ff} - {d0_ff[31], d0_ff};
   end

   // Divider
   logic [DVD_W-1:0] dvd;
   logic [1:0]       col_sel;
   logic             div_done;
   logic [DVD_W-1:0] div_q;
   logic [CNT_W-1:0] div_r;

   assign col_sel = 2'(cmd.div_idx - DIV_COLOR0);

   always_comb begin
      case (cmd.div_idx)
         DIV_X:     dvd = {adx_ff, {FRAC_BITS{1'b0}}};
         DIV_Y:     dvd = {ady_ff, {FRAC_BITS{1'b0}}};
         DIV_DEPTH: dvd = DVD_W'(dmag_ff);
         default:   dvd = DVD_W'(cmag_ff[col_sel]);
      endcase
   end

   dlr_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (dvd),
      .divisor   (total_ff),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   // DDA state
   logic signed [STEP_W-1:0] stepx_ff, stepy_ff, stepq;
   logic signed [POS_W-1:0]  px_ff, py_ff;
   logic [31:0]              dq_ff, dacc_ff;
   logic [CNT_W-1:0]         dr_ff, dracc_ff;
   logic [7:0]               cq_ff [4];
   logic [CNT_W-1:0]         cr_ff [4];
   logic [7:0]               cacc_ff [4];
   logic [CNT_W-1:0]         cracc_ff [4];
   logic                     last_step;

   assign stepq     = $signed({1'b0, div_q});
   assign last_step = count_ff >= total_ff;

   // Remainder carry for the faded channels
   logic [CNT_W:0]   d_rsum;
   logic             d_wrap;
   logic [CNT_W:0]   c_rsum [4];
   logic             c_wrap [4];

   always_comb begin
      d_rsum = {1'b0, dracc_ff} + {1'b0, dr_ff};
      d_wrap = d_rsum >= {1'b0, total_ff};
      for (int k = 0; k < 4; k++) begin
         c_rsum[k] = {1'b0, cracc_ff[k]} + {1'b0, cr_ff[k]};
         c_wrap[k] = c_rsum[k] >= {1'b0, total_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.init) begin
         total_ff <= t_full[CNT_W-1:0];
         count_ff <= '0;
         adx_ff   <= adx[CNT_W-1:0];
         ady_ff   <= ady[CNT_W-1:0];
         sgnx_ff  <= dx[CRD_W-1];
         sgny_ff  <= dy[CRD_W-1];
         dsgn_ff  <= ddif[32];
         dmag_ff  <= ddif[32] ? -ddif : ddif;
         px_ff    <= POS_W'(sx_ff) <<< FRAC_BITS;
         py_ff    <= POS_W'(sy_ff) <<< FRAC_BITS;
         dacc_ff  <= '0;
         dracc_ff <= '0;
         for (int k = 0; k < 4; k++) begin
            csgn_ff[k]  <= cdif[k][8];
            cmag_ff[k]  <= cdif[k][8] ? 8'(-cdif[k]) : cdif[k][7:0];
            cacc_ff[k]  <= '0;
            cracc_ff[k] <= '0;
         end
      end else if (cmd.step) begin
         count_ff <= count_ff + 1'b1;
         px_ff    <= px_ff + POS_W'(stepx_ff);
         py_ff    <= py_ff + POS_W'(stepy_ff);
         dacc_ff  <= dacc_ff + dq_ff + 32'(d_wrap);
         dracc_ff <= d_wrap ? CNT_W'(d_rsum - {1'b0, total_ff}) : d_rsum[CNT_W-1:0];
         for (int k = 0; k < 4; k++) begin
            cacc_ff[k]  <= cacc_ff[k] + cq_ff[k] + 8'(c_wrap[k]);
            cracc_ff[k] <= c_wrap[k] ? CNT_W'(c_rsum[k] - {1'b0, total_ff})
                                     : c_rsum[k][CNT_W-1:0];
         end
      end
      if (cmd.div_capture) begin
         case (cmd.div_idx)
            DIV_X:     stepx_ff <= sgnx_ff ? -stepq : stepq;
            DIV_Y:     stepy_ff <= sgny_ff ? -stepq : stepq;
            DIV_DEPTH: begin
               dq_ff <= div_q[31:0];
               dr_ff <= div_r;
            end
            default: begin
               cq_ff[col_sel] <= div_q[7:0];
               cr_ff[col_sel] <= div_r;
            end
         endcase
      end
   end

   // Rounding, half away from zero, and signed sub-pixel offset
   logic              negx, negy;
   logic [POS_W-1:0]  mx, my, rmx, rmy;
   logic signed [OFS_W-1:0] omx, omy;
   logic [31:0]       colr, dep;

   always_comb begin
      negx = px_ff[POS_W-1];
      negy = py_ff[POS_W-1];
      mx   = negx ? POS_W'(-px_ff) : POS_W'(px_ff);
      my   = negy ? POS_W'(-py_ff) : POS_W'(py_ff);
      rmx  = (mx + POS_W'(HALF)) >> FRAC_BITS;
      rmy  = (my + POS_W'(HALF)) >> FRAC_BITS;
      omx  = mx[FRAC_BITS-1:0] < HALF ? $signed(OFS_W'(mx[FRAC_BITS-1:0]))
                                       : $signed(OFS_W'(mx[FRAC_BITS-1:0])) -
                                         $signed(OFS_W'(1) << FRAC_BITS);
      omy  = my[FRAC_BITS-1:0] < HALF ? $signed(OFS_W'(my[FRAC_BITS-1:0]))
                                       : $signed(OFS_W'(my[FRAC_BITS-1:0])) -
                                         $signed(OFS_W'(1) << FRAC_BITS);
      for (int k = 0; k < 4; k++) begin
         colr[8*k +: 8] = csgn_ff[k] ? c0_ff[8*k +: 8] - cacc_ff[k]
                                     : c0_ff[8*k +: 8] + cacc_ff[k];
      end
      dep = dsgn_ff ? d0_ff - dacc_ff : d0_ff + dacc_ff;
   end

   // Pixel stage
   logic [31:0]             pix_x_ff, pix_y_ff, pcol_ff, pdep_ff;
   logic signed [OFS_W-1:0] ox_ff, oy_ff;
   logic                    pdone_ff;
   logic [7:0]              a2_ff;

   always_ff @(posedge clock) begin
      if (cmd.step) begin
         pix_x_ff <= negx ? 32'(-rmx) : rmx[31:0];
         pix_y_ff <= negy ? 32'(-rmy) : rmy[31:0];
         ox_ff    <= negx ? -omx : omx;
         oy_ff    <= negy ? -omy : omy;
         pcol_ff  <= colr;
         pdep_ff  <= dep;
         pdone_ff <= last_step;
      end
   end

   // Alpha split for the anti-aliased pair
   logic signed [OFS_W:0]       fac_s;
   logic [FRAC_BITS:0]          fac_u;
   logic [FRAC_BITS+8:0]        prod;
   logic [7:0]                  a1;
   logic [31:0]                 x2, y2;

   always_comb begin
      fac_s = $signed((OFS_W + 1)'(1) << FRAC_BITS) -
              (ox_ff < 0 ? -(OFS_W + 1)'(ox_ff) : (OFS_W + 1)'(ox_ff)) -
              (oy_ff < 0 ? -(OFS_W + 1)'(oy_ff) : (OFS_W + 1)'(oy_ff));
      fac_u = fac_s < 0 ? '0 : fac_s[FRAC_BITS:0];
      prod  = pcol_ff[7:0] * fac_u;
      a1    = prod[FRAC_BITS +: 8];
      x2    = pix_x_ff;
      y2    = pix_y_ff;
      if (ox_ff != 0) begin
         x2 = ox_ff > 0 ? pix_x_ff + 32'd1 : pix_x_ff - 32'd1;
      end else begin
         y2 = oy_ff > 0 ? pix_y_ff + 32'd1 : pix_y_ff - 32'd1;
      end
   end

   // Output register
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_ff, out_in;
   logic         out_load;

   assign out_load = cmd.emit_zero | cmd.emit_first | cmd.emit_second;

   always_comb begin
      out_in = out_ff;
      if (cmd.emit_zero) begin
         out_in.pixel_x         = sx_ff[31:0];
         out_in.pixel_y         = sy_ff[31:0];
         out_in.pixel_color     = c0_ff;
         out_in.pixel_depth     = d0_ff;
         out_in.pixel_thickness = aa_ff ? 8'd1 : thick_ff;
         out_in.blend_pixel     = 1'b0;
         out_in.line_done       = 1'b1;
      end else if (cmd.emit_first) begin
         out_in.pixel_x         = pix_x_ff;
         out_in.pixel_y         = pix_y_ff;
         out_in.pixel_color     = aa_ff ? {pcol_ff[31:8], a1} : pcol_ff;
         out_in.pixel_depth     = pdep_ff;
         out_in.pixel_thickness = aa_ff ? 8'd1 : thick_ff;
         out_in.blend_pixel     = aa_ff;
         out_in.line_done       = pdone_ff;
      end else if (cmd.emit_second) begin
         out_in.pixel_x         = x2;
         out_in.pixel_y         = y2;
         out_in.pixel_color     = {pcol_ff[31:8], a2_ff};
         out_in.pixel_depth     = pdep_ff;
         out_in.pixel_thickness = 8'd1;
         out_in.blend_pixel     = 1'b1;
         out_in.line_done       = pdone_ff;
      end
      out_valid_in = out_load | (out_valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      if (cmd.emit_first) begin
         a2_ff <= pcol_ff[7:0] - a1;
      end
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_ff;

   assign status.drop          = drop;
   assign status.zero_len      = t_full == '0;
   assign status.div_done      = div_done;
   assign status.out_free      = ~out_valid_ff | rsp_ready;
   assign status.last_step     = last_step;
   assign status.second_needed = (ox_ff != 0) || (oy_ff != 0);
   assign status.aa            = aa_ff;

endmodule

### src/dlr_control.sv
// Controller: sequences line test, divider setup passes, stepping and output.
// Depends on dlr_pkg for the command and status structs.
module dlr_control import dlr_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           req_func,
   output logic           req_ready,
   input  dlr_status_type status,
   output dlr_cmd_type    cmd
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_CHECK    = 3'd1;
   localparam logic [2:0] S_DIV_GO   = 3'd2;
   localparam logic [2:0] S_DIV_WAIT = 3'd3;
   localparam logic [2:0] S_ZERO     = 3'd4;
   localparam logic [2:0] S_STEP     = 3'd5;
   localparam logic [2:0] S_EMIT1    = 3'd6;
   localparam logic [2:0] S_EMIT2    = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       active_ff, active_in;
   logic [2:0] idx_ff, idx_in;

   always_comb begin
      state_in  = state_ff;
      active_in = active_ff;
      idx_in    = idx_ff;
      cmd       = '0;
      cmd.div_idx = idx_ff;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (!req_func) begin
                  cmd.capture = 1'b1;
                  state_in    = S_CHECK;
               end else if (active_ff) begin
                  state_in = S_STEP;
               end
            end
         end
         S_CHECK: begin
            // a load always abandons the previous line
            active_in = 1'b0;
            if (status.drop) begin
               state_in = S_IDLE;
            end else if (status.zero_len) begin
               state_in = S_ZERO;
            end else begin
               cmd.init = 1'b1;
               idx_in   = DIV_X;
               state_in = S_DIV_GO;
            end
         end
         S_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (status.div_done) begin
               cmd.div_capture = 1'b1;
               if (idx_ff == DIV_LAST) begin
                  active_in = 1'b1;
                  state_in  = S_IDLE;
               end else begin
                  idx_in   = idx_ff + 3'd1;
                  state_in = S_DIV_GO;
               end
            end
         end
         S_ZERO: begin
            if (status.out_free) begin
               cmd.emit_zero = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_STEP: begin
            cmd.step = 1'b1;
            if (status.last_step) begin
               active_in = 1'b0;
            end
            state_in = S_EMIT1;
         end
         S_EMIT1: begin
            if (status.out_free) begin
               cmd.emit_first = 1'b1;
               state_in = (status.aa && status.second_needed) ? S_EMIT2 : S_IDLE;
            end
         end
         S_EMIT2: begin
            if (status.out_free) begin
               cmd.emit_second = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (reset) begin
         state_ff  <= S_IDLE;
         active_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         active_ff <= active_in;
      end
   end

endmodule

### src/dda_line_rasterizer.sv
// DDA line rasterizer top level. Load transaction: the line is tested first; a drawable
// line then takes 7 divider passes before stepping. Step transaction: S_STEP advances
// the DDA into the pixel stage, S_EMIT1 loads the first pixel and, when anti-aliased with
// a nonzero offset, S_EMIT2 the second; each emit waits for a free output register.
// Setup time is set by the shared one-bit-per-cycle divider. New requests wait for S_IDLE.
// Synchronous active-high reset: CSRs to defaults, no line active, output empty.
module dda_line_rasterizer import dlr_pkg::*; (
   input logic        clock,
   input logic        reset,
   dlr_req_if.sink    req_ch,
   dlr_rsp_if.source  rsp_ch,
   dlr_csr_if.sink    csr_ch
);

   req_item_type   req_item;
   rsp_item_type   rsp_item;
   csr_write_type  csr_wr;
   dlr_cmd_type    cmd;
   dlr_status_type status;
   logic           req_ready;
   logic           rsp_valid;

   // Pack the request transaction for the datapath
   assign req_item.func        = req_ch.func;
   assign req_item.start_x     = req_ch.start_x;
   assign req_item.start_y     = req_ch.start_y;
   assign req_item.end_x       = req_ch.end_x;
   assign req_item.end_y       = req_ch.end_y;
   assign req_item.start_color = req_ch.start_color;
   assign req_item.end_color   = req_ch.end_color;
   assign req_item.start_depth = req_ch.start_depth;
   assign req_item.end_depth   = req_ch.end_depth;
   assign req_item.start_shown = req_ch.start_shown;
   assign req_item.end_shown   = req_ch.end_shown;
   assign req_ch.ready         = req_ready;

   // CSR writes are always taken
   assign csr_ch.ready = 1'b1;
   assign csr_wr.valid = csr_ch.valid;
   assign csr_wr.index = csr_ch.index;
   assign csr_wr.data  = csr_ch.data;

   dlr_control u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_func  (req_ch.func),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   dlr_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .csr_wr    (csr_wr),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .rsp_ready (rsp_ch.ready)
   );

   // Drive the response channel from the output register
   assign rsp_ch.valid           = rsp_valid;
   assign rsp_ch.pixel_x         = rsp_item.pixel_x;
   assign rsp_ch.pixel_y         = rsp_item.pixel_y;
   assign rsp_ch.pixel_color     = rsp_item.pixel_color;
   assign rsp_ch.pixel_depth     = rsp_item.pixel_depth;
   assign rsp_ch.pixel_thickness = rsp_item.pixel_thickness;
   assign rsp_ch.blend_pixel     = rsp_item.blend_pixel;
   assign rsp_ch.line_done       = rsp_item.line_done;

endmodule

### bench/dlr_line_checker.sv
`timescale 1ns / 1ps
// Pixel checker for the DDA line rasterizer: watches the request, response and CSR
// channels, predicts every pixel and compares it. Depends on dlr_pkg and dlr_if.
module dlr_line_checker import dlr_pkg::*; (
   input  logic clock,
   input  logic reset,
   dlr_req_if   req,
   dlr_rsp_if   rsp,
   dlr_csr_if   csr,
   output int   mismatches,
   output int   pixels_pending,
   output int   pixels_seen,
   output int   lines_loaded
);

   // shadow registers
   logic [15:0] cfg_width, cfg_height;
   logic        cfg_ortho, cfg_aa;
   logic [7:0]  cfg_thick;

   // line state
   logic        drawing;
   longint      step_idx, step_cnt;
   longint      org_x, org_y, inc_x, inc_y;
   logic [31:0] col_start, col_end;
   longint      dep_start, dep_end;

   rsp_item_type pixel_q[$];

   function automatic longint round_half_away(longint p);
      if (p >= 0) return (p + 64'sd32768) >>> FRAC_BITS;
      return -((-p + 64'sd32768) >>> FRAC_BITS);
   endfunction

   function automatic logic [31:0] ramp_rgba(logic [31:0] c0, logic [31:0] c1,
                                             longint i, longint t);
      logic [31:0] r;
      longint s, e;
      r = '0;
      for (int ch = 0; ch < 4; ch++) begin
         s = longint'(c0[ch*8 +: 8]);
         e = longint'(c1[ch*8 +: 8]);
         r[ch*8 +: 8] = 8'(s + ((e - s) * i) / t);
      end
      return r;
   endfunction

   task automatic push_pixel(longint x, longint y, logic [31:0] c, longint d,
                             logic [7:0] th, logic bl, logic dn);
      rsp_item_type p;
      p.pixel_x = 32'(x);
      p.pixel_y = 32'(y);
      p.pixel_color = c;
      p.pixel_depth = 32'(d);
      p.pixel_thickness = th;
      p.blend_pixel = bl;
      p.line_done = dn;
      pixel_q.push_back(p);
   endtask

   task automatic predict_load(req_item_type it);
      longint sx, sy, ex, ey, w, h, lim, dx, dy, t;
      sx = longint'(signed'(it.start_x));
      sy = longint'(signed'(it.start_y));
      ex = longint'(signed'(it.end_x));
      ey = longint'(signed'(it.end_y));
      w = longint'(cfg_width);
      h = longint'(cfg_height);
      lim = cfg_ortho ? LIMIT_ORTHO : LIMIT_PERSP;
      drawing = 1'b0;
      // drop: both ends past one edge, beyond the widened limit, hidden, or transparent
      if ((sx > w && ex > w) || (sx < 0 && ex < 0)) return;
      if ((sy > h && ey > h) || (sy < 0 && ey < 0)) return;
      if (sx > w + lim || sy > h + lim || sx < -lim || sy < -lim) return;
      if (ex > w + lim || ey > h + lim || ex < -lim || ey < -lim) return;
      if (!it.start_shown || !it.end_shown) return;
      if (it.start_color[7:0] == 0 && it.end_color[7:0] == 0) return;
      dx = ex - sx;
      dy = ey - sy;
      t = (dx < 0 ? -dx : dx) > (dy < 0 ? -dy : dy) ? (dx < 0 ? -dx : dx)
                                                     : (dy < 0 ? -dy : dy);
      lines_loaded++;
      if (t == 0) begin
         push_pixel(sx, sy, it.start_color, longint'(signed'(it.start_depth)),
                    cfg_aa ? 8'd1 : cfg_thick, 1'b0, 1'b1);
         return;
      end
      org_x = sx;
      org_y = sy;
      inc_x = (dx * (64'sd1 <<< FRAC_BITS)) / t;
      inc_y = (dy * (64'sd1 <<< FRAC_BITS)) / t;
      col_start = it.start_color;
      col_end = it.end_color;
      dep_start = longint'(signed'(it.start_depth));
      dep_end = longint'(signed'(it.end_depth));
      step_cnt = t;
      step_idx = 0;
      drawing = 1'b1;
   endtask

   task automatic predict_step();
      longint px, py, rx, ry, d, ox, oy, fac, a, a1;
      logic [31:0] c;
      logic dn;
      if (!drawing) return;
      px = org_x * (64'sd1 <<< FRAC_BITS) + inc_x * step_idx;
      py = org_y * (64'sd1 <<< FRAC_BITS) + inc_y * step_idx;
      c = ramp_rgba(col_start, col_end, step_idx, step_cnt);
      d = dep_start + ((dep_end - dep_start) * step_idx) / step_cnt;
      dn = step_idx >= step_cnt;
      rx = round_half_away(px);
      ry = round_half_away(py);
      if (cfg_aa) begin
         ox = px - rx * (64'sd1 <<< FRAC_BITS);
         oy = py - ry * (64'sd1 <<< FRAC_BITS);
         fac = (64'sd1 <<< FRAC_BITS) - (ox < 0 ? -ox : ox) - (oy < 0 ? -oy : oy);
         if (fac < 0) fac = 0;
         a = longint'(c[7:0]);
         a1 = (a * fac) >>> FRAC_BITS;
         push_pixel(rx, ry, {c[31:8], 8'(a1)}, d, 8'd1, 1'b1, dn);
         // split the remaining alpha onto the neighbor toward the offset
         if (ox != 0 || oy != 0) begin
            if (ox != 0) rx += (ox > 0) ? 1 : -1;
            else ry += (oy > 0) ? 1 : -1;
            push_pixel(rx, ry, {c[31:8], 8'(a - a1)}, d, 8'd1, 1'b1, dn);
         end
      end else begin
         push_pixel(rx, ry, c, d, cfg_thick, 1'b0, dn);
      end
      step_idx++;
      if (dn) drawing = 1'b0;
   endtask

   task automatic compare_pixel();
      rsp_item_type got, want;
      got.pixel_x = rsp.pixel_x;
      got.pixel_y = rsp.pixel_y;
      got.pixel_color = rsp.pixel_color;
      got.pixel_depth = rsp.pixel_depth;
      got.pixel_thickness = rsp.pixel_thickness;
      got.blend_pixel = rsp.blend_pixel;
      got.line_done = rsp.line_done;
      pixels_seen++;
      if (pixel_q.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t unexpected pixel x=%0d y=%0d", $realtime,
                     signed'(got.pixel_x), signed'(got.pixel_y));
         return;
      end
      want = pixel_q.pop_front();
      if (got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y ||
          got.pixel_color !== want.pixel_color || got.pixel_depth !== want.pixel_depth ||
          got.pixel_thickness !== want.pixel_thickness ||
          got.blend_pixel !== want.blend_pixel || got.line_done !== want.line_done) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("%0t pixel mismatch", $realtime);
            $display("  expected x=%0d y=%0d col=%h dep=%h th=%0d bl=%b dn=%b",
                     signed'(want.pixel_x), signed'(want.pixel_y), want.pixel_color,
                     want.pixel_depth, want.pixel_thickness, want.blend_pixel,
                     want.line_done);
            $display("  actual   x=%0d y=%0d col=%h dep=%h th=%0d bl=%b dn=%b",
                     signed'(got.pixel_x), signed'(got.pixel_y), got.pixel_color,
                     got.pixel_depth, got.pixel_thickness, got.blend_pixel,
                     got.line_done);
         end
      end
   endtask

   initial begin
      mismatches = 0;
      pixels_seen = 0;
      lines_loaded = 0;
      drawing = 1'b0;
   end

   assign pixels_pending = pixel_q.size();

   always @(posedge clock) begin
      if (reset) begin
         cfg_width <= RST_CANVAS_WIDTH;
         cfg_height <= RST_CANVAS_HEIGHT;
         cfg_ortho <= 1'b0;
         cfg_aa <= 1'b0;
         cfg_thick <= RST_THICKNESS;
         drawing = 1'b0;
         pixel_q.delete();
      end else begin
         if (req.valid && req.ready) begin
            req_item_type it;
            it = {req.func, req.start_x, req.start_y, req.end_x, req.end_y,
                  req.start_color, req.end_color, req.start_depth, req.end_depth,
                  req.start_shown, req.end_shown};
            if (it.func) predict_step();
            else predict_load(it);
         end
         if (rsp.valid && rsp.ready) compare_pixel();
         if (csr.valid && csr.ready) begin
            case (csr.index)
               CSR_CANVAS_WIDTH:  cfg_width <= csr.data;
               CSR_CANVAS_HEIGHT: cfg_height <= csr.data;
               CSR_ORTHO_MODE:    cfg_ortho <= csr.data[0];
               CSR_AA_MODE:       cfg_aa <= csr.data[0];
               CSR_THICKNESS:     cfg_thick <= csr.data[7:0];
               default: ;
            endcase
         end
      end
   end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// Top of the DDA line rasterizer bench: clock, reset, stimulus and verdict.
// Depends on dlr_pkg, dlr_if, dda_line_rasterizer and dlr_line_checker.
module tb_top;
   import dlr_pkg::*;

   localparam int SETTLE = 400;   // covers a full line setup that yields nothing

   logic clock;
   logic reset;

   dlr_req_if req_ch ();
   dlr_rsp_if rsp_ch ();
   dlr_csr_if csr_ch ();

   int mismatches, pixels_pending, pixels_seen, lines_loaded;
   int send_idle_pct, rsp_stall_pct;
   int items_sent;
   logic hold_toggle, hold_seen;
   int   hold_left;
   logic [15:0] cur_w, cur_h;

   dda_line_rasterizer dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   dlr_line_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req           (req_ch),
      .rsp           (rsp_ch),
      .csr           (csr_ch),
      .mismatches    (mismatches),
      .pixels_pending(pixels_pending),
      .pixels_seen   (pixels_seen),
      .lines_loaded  (lines_loaded)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Receiver: random stalls, plus a long hold-off whenever the stimulus flips the toggle.
   always @(posedge clock) begin
      if (hold_toggle != hold_seen) begin
         hold_seen <= hold_toggle;
         hold_left <= 300;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // Drive one request transaction; hold it until the block takes it.
   task automatic send(req_item_type it);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.func <= it.func;
      req_ch.start_x <= it.start_x;
      req_ch.start_y <= it.start_y;
      req_ch.end_x <= it.end_x;
      req_ch.end_y <= it.end_y;
      req_ch.start_color <= it.start_color;
      req_ch.end_color <= it.end_color;
      req_ch.start_depth <= it.start_depth;
      req_ch.end_depth <= it.end_depth;
      req_ch.start_shown <= it.start_shown;
      req_ch.end_shown <= it.end_shown;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
   endtask

   // Step items carry random payload bits, which the block must ignore.
   function automatic req_item_type step_item();
      req_item_type it;
      logic [287:0] raw;
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom};
      it = raw[$bits(req_item_type)-1:0];
      it.func = 1'b1;
      return it;
   endfunction

   function automatic req_item_type load_item(int sx, int sy, int ex, int ey);
      req_item_type it;
      it.func = 1'b0;
      it.start_x = sx;
      it.start_y = sy;
      it.end_x = ex;
      it.end_y = ey;
      it.start_color = $urandom;
      it.end_color = $urandom;
      it.start_depth = $urandom;
      it.end_depth = $urandom;
      it.start_shown = 1'b1;
      it.end_shown = 1'b1;
      return it;
   endfunction

   function automatic int line_len(req_item_type it);
      int ax, ay;
      ax = signed'(it.end_x) - signed'(it.start_x);
      ay = signed'(it.end_y) - signed'(it.start_y);
      if (ax < 0) ax = -ax;
      if (ay < 0) ay = -ay;
      return ax > ay ? ax : ay;
   endfunction

   // A drawable-ish line near the canvas, mostly short.
   function automatic req_item_type random_line();
      int sx, sy, span;
      span = ($urandom_range(0, 7) == 0) ? 60 : 10;
      sx = int'($urandom_range(0, cur_w + 20)) - 10;
      sy = int'($urandom_range(0, cur_h + 20)) - 10;
      return load_item(sx, sy, sx + int'($urandom_range(0, 2 * span)) - span,
                       sy + int'($urandom_range(0, 2 * span)) - span);
   endfunction

   task automatic draw(req_item_type it, int steps);
      send(it);
      repeat (steps) send(step_item());
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (pixels_pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= val;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      if (idx == CSR_CANVAS_WIDTH) cur_w = val;
      if (idx == CSR_CANVAS_HEIGHT) cur_h = val;
   endtask

   task automatic configure(logic [15:0] w, logic [15:0] h, logic ortho, logic aa,
                            logic [7:0] th);
      drain();
      csr_write(CSR_CANVAS_WIDTH, w);
      csr_write(CSR_CANVAS_HEIGHT, h);
      csr_write(CSR_ORTHO_MODE, {15'd0, ortho});
      csr_write(CSR_AA_MODE, {15'd0, aa});
      csr_write(CSR_THICKNESS, {8'd0, th});
   endtask

   task automatic directed();
      req_item_type it;
      send(step_item());                              // step with no line: nothing
      draw(load_item(10, 10, 10, 10), 0);             // zero length: start pixel at once
      draw(load_item(100, 200, 107, 195), 8);         // plain line to its end
      draw(load_item(-5, -5, 3, 9), 15);              // starts off canvas, crosses in
      draw(load_item(50, 50, 90, 60), 5);             // abandon it midway...
      draw(load_item(60, 60, 55, 57), 6);             // ...with a fresh load
      draw(load_item(2000, 5, 2100, 9), 3);           // both ends right of canvas
      draw(load_item(5, -3, 9, -1), 2);               // both ends above canvas
      draw(load_item(5, 5, 5, 60000), 2);             // beyond widened limit
      draw(load_item(32'sh8000_0000, 5, 32'sh7fff_ffff, 9), 1); // coordinate extremes
      it = load_item(5, 5, 9, 9);
      it.start_shown = 1'b0;
      draw(it, 1);                                    // hidden start point
      it = load_item(5, 5, 9, 9);
      it.end_shown = 1'b0;
      draw(it, 1);                                    // hidden end point
      it = load_item(5, 5, 9, 9);
      it.start_color[7:0] = 8'd0;
      it.end_color[7:0] = 8'd0;
      draw(it, 1);                                    // fully transparent
      it = load_item(1920, 1080, 1916, 1077);
      it.start_color = 32'hffff_ffff;
      it.end_color = 32'h0000_0000;
      it.start_depth = 32'sh7fff_ffff;
      it.end_depth = 32'sh8000_0000;
      draw(it, 5);                                    // extremes of color and depth
   endtask

   task automatic random_phase(int count);
      req_item_type it;
      logic [287:0] raw;
      int stop_at, n;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         case ($urandom_range(0, 9))
            0: begin
               // noise: fully random load, mostly dropped
               raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom};
               it = raw[$bits(req_item_type)-1:0];
               it.func = 1'b0;
               send(it);
            end
            1: send(step_item());
            default: begin
               it = random_line();
               n = line_len(it) + 1;
               if ($urandom_range(0, 9) == 0) n = $urandom_range(0, n);
               else if ($urandom_range(0, 9) == 0) n += $urandom_range(1, 3);
               draw(it, n);
            end
         endcase
      end
   endtask

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.func = 1'b0;
      req_ch.start_x = '0;
      req_ch.start_y = '0;
      req_ch.end_x = '0;
      req_ch.end_y = '0;
      req_ch.start_color = '0;
      req_ch.end_color = '0;
      req_ch.start_depth = '0;
      req_ch.end_depth = '0;
      req_ch.start_shown = 1'b0;
      req_ch.end_shown = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = '0;
      csr_ch.data = '0;
      rsp_ch.ready = 1'b0;
      hold_toggle = 1'b0;
      hold_seen = 1'b0;
      hold_left = 0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      items_sent = 0;
      cur_w = RST_CANVAS_WIDTH;
      cur_h = RST_CANVAS_HEIGHT;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed();

      // hold off the receiver while a long line keeps stepping: input must stall
      draw(load_item(0, 0, 400, 120), 1);
      hold_toggle <= ~hold_toggle;
      repeat (60) send(step_item());
      drain();
      configure(16'd640, 16'd480, 1'b0, 1'b1, 8'd1);
      directed();

      // phases: no idling, sender idle, receiver stalling, both, then no idling again
      send_idle_pct = 0;  rsp_stall_pct = 0;
      random_phase(220);
      configure(16'd0, 16'd0, 1'b1, 1'b1, 8'd255);
      send_idle_pct = 53; rsp_stall_pct = 0;
      random_phase(220);
      configure(16'hffff, 16'hffff, 1'b1, 1'b0, 8'd0);
      send_idle_pct = 0;  rsp_stall_pct = 53;
      random_phase(220);
      configure(16'($urandom_range(1, 4000)), 16'($urandom_range(1, 4000)),
                1'($urandom), 1'b1, 8'($urandom));
      send_idle_pct = 20; rsp_stall_pct = 20;
      random_phase(220);
      configure(16'd1920, 16'd1080, 1'b0, 1'b0, 8'd7);
      send_idle_pct = 0;  rsp_stall_pct = 0;
      random_phase(200);

      drain();
      $display("Sent %0d transactions; %0d lines drawn, %0d pixels checked,",
               items_sent, lines_loaded, pixels_seen);
      $display("plain and anti-aliased modes, canvas extremes, both visibility limits.");
      if (mismatches == 0) begin
         $display("PASS dda_line_rasterizer");
      end else begin
         $display("FAIL dda_line_rasterizer");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("Timeout with %0d pixels outstanding", pixels_pending);
      $display("FAIL dda_line_rasterizer");
      $finish;
   end

endmodule
